// ===== src/alpb_pkg.sv =====
`timescale 1ns / 1ps

package alpb_pkg;

  // Channel width and the largest channel value.
  localparam int CHAN_W   = 8;
  localparam int CHAN_MAX = 255;

  // Number of level inputs and tint registers that exist on the ports.
  localparam int PHYS_LAYERS = 4;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int COUNT_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_LAYERS   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER0_COLOR = 3'd1;

  // One RGB888 value; the packing matches the tint registers.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Exact floor(p / 255) for any 16-bit product of two 8-bit values.
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] t;
    t = {1'b0, p} + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== src/alpb_lane.sv =====
`timescale 1ns / 1ps

module alpb_lane (
  input  logic                           clk,
  input  alpb_pkg::rgb_t                 tint,
  input  logic [alpb_pkg::CHAN_W-1:0]    level,
  input  logic                           en,
  output alpb_pkg::rgb_t                 quot
);
  import alpb_pkg::*;

  logic [CHAN_W-1:0]   lvl;
  logic [2*CHAN_W-1:0] prod_red;
  logic [2*CHAN_W-1:0] prod_green;
  logic [2*CHAN_W-1:0] prod_blue;

  // A disabled layer contributes nothing, so its level is forced to zero.
  assign lvl = en ? level : '0;

  // First stage: one 8x8 product per channel.
  always_ff @(posedge clk) begin
    prod_red   <= tint.red   * lvl;
    prod_green <= tint.green * lvl;
    prod_blue  <= tint.blue  * lvl;
  end

  // Second stage: scale each product back to the channel range.
  always_ff @(posedge clk) begin
    quot.red   <= div255(prod_red);
    quot.green <= div255(prod_green);
    quot.blue  <= div255(prod_blue);
  end

endmodule

// ===== src/alpb_merge.sv =====
`timescale 1ns / 1ps

module alpb_merge #(
  parameter int NUM_LANES = 4
) (
  input  logic           clk,
  input  alpb_pkg::rgb_t bg,
  input  alpb_pkg::rgb_t quot [NUM_LANES],
  output alpb_pkg::rgb_t pix
);
  import alpb_pkg::*;

  localparam int SUM_W = CHAN_W + $clog2(NUM_LANES + 1);

  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;

  // Add the background and every lane's contribution per channel.
  always_comb begin
    sum_red   = SUM_W'(bg.red);
    sum_green = SUM_W'(bg.green);
    sum_blue  = SUM_W'(bg.blue);
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_red   = sum_red   + SUM_W'(quot[i].red);
      sum_green = sum_green + SUM_W'(quot[i].green);
      sum_blue  = sum_blue  + SUM_W'(quot[i].blue);
    end
  end

  // Saturate each channel at full scale and register the pixel.
  always_ff @(posedge clk) begin
    pix.red   <= (sum_red   > SUM_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : sum_red[CHAN_W-1:0];
    pix.green <= (sum_green > SUM_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : sum_green[CHAN_W-1:0];
    pix.blue  <= (sum_blue  > SUM_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : sum_blue[CHAN_W-1:0];
  end

endmodule

// ===== src/additive_layer_pixel_blend_unit.sv =====
`timescale 1ns / 1ps

// Additive tinted-layer pixel blender. One pixel is taken on every clock at
// which start is high; busy never rises, so pixels may stream back to back
// without a gap. Each pixel comes out once it has passed the pipeline, as a
// single-cycle beat marked by done, and results leave in the order the pixels
// came in. The receiver cannot stall the block and must take every beat. The
// pipeline has one stage of 8x8 multipliers, one stage that scales each
// product by 1/255, and the merge stage that adds the layers to the
// background and saturates. Layer tints and the layer count are written
// through the cfg port, which is always ready, and should only be changed
// while no pixel is in flight.
module additive_layer_pixel_blend_unit #(
  parameter int MAX_LAYERS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  // Pixel command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [7:0]                         bg_red,
  input  logic [7:0]                         bg_green,
  input  logic [7:0]                         bg_blue,
  input  logic [7:0]                         layer0_level,
  input  logic [7:0]                         layer1_level,
  input  logic [7:0]                         layer2_level,
  input  logic [7:0]                         layer3_level,
  // Result strobe
  output logic                               done,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [alpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import alpb_pkg::*;

  localparam int NUM_LANES = (MAX_LAYERS < PHYS_LAYERS) ? MAX_LAYERS : PHYS_LAYERS;
  localparam int LANE_CNT_W = COUNT_W + 1;

  logic [COUNT_W-1:0]    num_layers;
  rgb_t                  tint [NUM_LANES];
  logic [LANE_CNT_W-1:0] eff_count;
  logic [CHAN_W-1:0]     level_in [PHYS_LAYERS];
  rgb_t                  quot [NUM_LANES];
  rgb_t                  bg_in;
  rgb_t                  bg_d1;
  rgb_t                  bg_d2;
  rgb_t                  pix;
  logic                  accept;
  logic                  cfg_write;
  logic                  valid_s1;
  logic                  valid_s2;
  logic                  valid_s3;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Layer count register; counts above the lane count saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers <= '0;
    end else if (cfg_write && cfg_index == REG_NUM_LAYERS) begin
      num_layers <= cfg_data[COUNT_W-1:0];
    end
  end

  assign eff_count = (LANE_CNT_W'(num_layers) > LANE_CNT_W'(NUM_LANES)) ?
                     LANE_CNT_W'(NUM_LANES) : LANE_CNT_W'(num_layers);

  assign level_in[0] = layer0_level;
  assign level_in[1] = layer1_level;
  assign level_in[2] = layer2_level;
  assign level_in[3] = layer3_level;

  // One tint register and one blend lane per layer.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        tint[i] <= '0;
      end else if (cfg_write && cfg_index == CFG_INDEX_W'(REG_LAYER0_COLOR + i)) begin
        tint[i] <= rgb_t'(cfg_data);
      end
    end

    alpb_lane u_lane (
      .clk   (clk),
      .tint  (tint[i]),
      .level (level_in[i]),
      .en    (LANE_CNT_W'(i) < eff_count),
      .quot  (quot[i])
    );
  end

  // Background rides alongside the two lane stages.
  assign bg_in = '{red: bg_red, green: bg_green, blue: bg_blue};

  always_ff @(posedge clk) begin
    bg_d1 <= bg_in;
    bg_d2 <= bg_d1;
  end

  alpb_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk  (clk),
    .bg   (bg_d2),
    .quot (quot),
    .pix  (pix)
  );

  // Beat tracking through the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
    end else begin
      valid_s1 <= accept;
      valid_s2 <= valid_s1;
      valid_s3 <= valid_s2;
    end
  end

  assign done      = valid_s3;
  assign out_red   = pix.red;
  assign out_green = pix.green;
  assign out_blue  = pix.blue;

  // Every accepted pixel produces a result beat.
  assert property (@(posedge clk) disable iff (rst) accept |-> ##3 done)
    else $error("accepted pixel did not produce a result beat");

  // No beat appears without a pixel accepted earlier, traced back through valid_s2 and valid_s1.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid_s2) && $past(valid_s1, 2))
    else $error("result beat without a matching accepted pixel");

  // With no layers enabled the pixel passes through unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (done && num_layers == '0 && $stable(num_layers) && $past(valid_s2)) |->
      out_red == $past(bg_d2.red) &&
      out_green == $past(bg_d2.green) && out_blue == $past(bg_d2.blue))
    else $error("pass-through pixel altered with no layers enabled");

endmodule

// ===== test/tb_additive_layer_pixel_blend_unit.sv =====
`timescale 1ns / 1ps

module tb_additive_layer_pixel_blend_unit;
  import alpb_pkg::*;

  // Layer limit the block is built with, and its pipeline depth from start to done.
  localparam int DUT_LAYERS = 4;
  localparam int PIPE_DEPTH = 3;

  // First register index past the end of the register list.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_LAYER0_COLOR + PHYS_LAYERS;

  // One pixel as the block takes it.
  typedef struct packed {
    rgb_t                                bg;
    logic [PHYS_LAYERS-1:0][CHAN_W-1:0] level;
  } pixel_t;

  // One row of the directed table: either a register write or a pixel.
  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    data;
    pixel_t                   px;
    logic                     has_want;
    rgb_t                     want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [7:0]             bg_red;
  logic [7:0]             bg_green;
  logic [7:0]             bg_blue;
  logic [7:0]             layer0_level;
  logic [7:0]             layer1_level;
  logic [7:0]             layer2_level;
  logic [7:0]             layer3_level;
  logic                   done;
  logic [7:0]             out_red;
  logic [7:0]             out_green;
  logic [7:0]             out_blue;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Local copy of the block's registers.
  logic [COUNT_W-1:0] num_layers_q;
  rgb_t               tint_q [PHYS_LAYERS];

  // Blended pixels still owed by the block, oldest first.
  rgb_t pending_px [$];
  rgb_t want_px;
  int   errors;

  additive_layer_pixel_blend_unit #(
    .MAX_LAYERS(DUT_LAYERS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .bg_red       (bg_red),
    .bg_green     (bg_green),
    .bg_blue      (bg_blue),
    .layer0_level (layer0_level),
    .layer1_level (layer1_level),
    .layer2_level (layer2_level),
    .layer3_level (layer3_level),
    .done         (done),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blend one pixel with the current tints and layer count.
  function automatic rgb_t blend_pixel(input pixel_t p);
    int   n;
    int   i;
    int   sum_r;
    int   sum_g;
    int   sum_b;
    rgb_t t;
    rgb_t o;
    n = int'(num_layers_q);
    if (n > DUT_LAYERS) n = DUT_LAYERS;
    if (n > PHYS_LAYERS) n = PHYS_LAYERS;
    sum_r = int'(p.bg.red);
    sum_g = int'(p.bg.green);
    sum_b = int'(p.bg.blue);
    for (i = 0; i < n; i++) begin
      t = tint_q[i];
      sum_r += (int'(t.red) * int'(p.level[i])) / CHAN_MAX;
      sum_g += (int'(t.green) * int'(p.level[i])) / CHAN_MAX;
      sum_b += (int'(t.blue) * int'(p.level[i])) / CHAN_MAX;
    end
    o.red   = (sum_r > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : CHAN_W'(sum_r);
    o.green = (sum_g > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : CHAN_W'(sum_g);
    o.blue  = (sum_b > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : CHAN_W'(sum_b);
    return o;
  endfunction

  // Table row builders.
  function automatic row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, px: '0, has_want: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t pixel_row(input logic [7:0] r, g, b, l0, l1, l2, l3);
    row_t row;
    row = '{kind: ROW_PIXEL, idx: '0, data: '0, px: '0, has_want: 1'b0, want: '0};
    row.px.bg    = {r, g, b};
    row.px.level = {l3, l2, l1, l0};
    return row;
  endfunction

  function automatic row_t checked_row(input logic [7:0] r, g, b, l0, l1, l2, l3,
                                       input logic [23:0] want);
    row_t row;
    row          = pixel_row(r, g, b, l0, l1, l2, l3);
    row.has_want = 1'b1;
    row.want     = want;
    return row;
  endfunction

  // Random values that land on the extremes now and then.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_tint();
    case ($urandom_range(7))
      0, 1:    return '1;
      2:       return '0;
      default: return {rand_chan(), rand_chan(), rand_chan()};
    endcase
  endfunction

  // Present one pixel and hold it until the block takes the beat.
  task automatic send_pixel(input pixel_t p);
    @(negedge clk);
    start        <= 1'b1;
    bg_red       <= p.bg.red;
    bg_green     <= p.bg.green;
    bg_blue      <= p.bg.blue;
    layer0_level <= p.level[0];
    layer1_level <= p.level[1];
    layer2_level <= p.level[2];
    layer3_level <= p.level[3];
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Stop sending and wait until every owed pixel has come back.
  task automatic drain_pipeline();
    idle_cycle();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Write one register and mirror it in the local copy.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_LAYERS) begin
      num_layers_q = data[COUNT_W-1:0];
    end else if (idx >= REG_LAYER0_COLOR && idx < REG_FIRST_UNUSED) begin
      tint_q[idx - REG_LAYER0_COLOR] = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare every result beat with the oldest owed pixel.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h%h%h",
                 $time, out_red, out_green, out_blue);
        errors++;
      end else begin
        want_px = pending_px.pop_front();
        check_chan("out_red", want_px.red, out_red);
        check_chan("out_green", want_px.green, out_green);
        check_chan("out_blue", want_px.blue, out_blue);
      end
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t   dir_rows [$];
    row_t   row;
    pixel_t px;
    int     gap_pct [4];
    int     phase;
    int     seg;
    int     k;
    int     i;

    errors        = 0;
    num_layers_q  = '0;
    for (i = 0; i < PHYS_LAYERS; i++) tint_q[i] = '0;
    rst          = 1'b1;
    start        = 1'b0;
    bg_red       = '0;
    bg_green     = '0;
    bg_blue      = '0;
    layer0_level = '0;
    layer1_level = '0;
    layer2_level = '0;
    layer3_level = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed table. With no layers the background passes through untouched.
    dir_rows.push_back(checked_row(8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'h123456));
    dir_rows.push_back(checked_row(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'h000000));
    dir_rows.push_back(checked_row(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 24'hFFFFFF));
    // All four layers at full white.
    dir_rows.push_back(cfg_row(REG_NUM_LAYERS, 24'd4));
    for (i = 0; i < PHYS_LAYERS; i++) begin
      dir_rows.push_back(cfg_row(REG_LAYER0_COLOR + CFG_INDEX_W'(i), 24'hFFFFFF));
    end
    dir_rows.push_back(checked_row(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF));
    dir_rows.push_back(checked_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 24'h000000));
    dir_rows.push_back(checked_row(8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 24'hFFFFFF));
    dir_rows.push_back(checked_row(8'h10, 8'h20, 8'h30, 8'h01, 8'h00, 8'h00, 8'h00, 24'h112131));
    dir_rows.push_back(checked_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF));
    // Mixed tints, so each layer adds a distinct amount per channel.
    dir_rows.push_back(cfg_row(REG_LAYER0_COLOR, 24'h804020));
    dir_rows.push_back(cfg_row(REG_LAYER0_COLOR + 3'd1, 24'h123456));
    dir_rows.push_back(cfg_row(REG_LAYER0_COLOR + 3'd2, 24'hA5C3E7));
    dir_rows.push_back(cfg_row(REG_LAYER0_COLOR + 3'd3, 24'h00FF00));
    dir_rows.push_back(pixel_row(8'h80, 8'h40, 8'h20, 8'h80, 8'h7F, 8'hC0, 8'h01));
    // A layer count past the top behaves as four layers.
    dir_rows.push_back(cfg_row(REG_NUM_LAYERS, 24'd7));
    dir_rows.push_back(pixel_row(8'h01, 8'hFE, 8'h55, 8'hAA, 8'h55, 8'hFF, 8'hFE));
    // Two layers: levels of layers two and three must be ignored.
    dir_rows.push_back(cfg_row(REG_NUM_LAYERS, 24'd2));
    dir_rows.push_back(pixel_row(8'h33, 8'h66, 8'h99, 8'h40, 8'hC0, 8'hFF, 8'hFF));
    // Writes past the end of the register list change nothing.
    dir_rows.push_back(cfg_row(REG_FIRST_UNUSED, 24'hFFFFFF));
    dir_rows.push_back(cfg_row(3'd7, 24'hFFFFFF));
    dir_rows.push_back(pixel_row(8'hC8, 8'h07, 8'h80, 8'hFF, 8'h80, 8'hFF, 8'hFF));
    dir_rows.push_back(cfg_row(REG_NUM_LAYERS, 24'd0));
    dir_rows.push_back(checked_row(8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'h123456));

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        drain_pipeline();
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.px);
        pending_px.push_back(row.has_want ? row.want : blend_pixel(row.px));
      end
    end

    // Random part: phases with different idle rates, each with several register settings.
    gap_pct = '{0, 85, 8, 0};
    for (phase = 0; phase < 4; phase++) begin
      for (seg = 0; seg < 6; seg++) begin
        drain_pipeline();
        write_reg(REG_NUM_LAYERS, CFG_DATA_W'($urandom_range(7)));
        for (i = 0; i < PHYS_LAYERS; i++) begin
          write_reg(REG_LAYER0_COLOR + CFG_INDEX_W'(i), rand_tint());
        end
        if ($urandom_range(2) == 0) begin
          write_reg(CFG_INDEX_W'($urandom_range(7, int'(REG_FIRST_UNUSED))), rand_tint());
        end
        for (k = 0; k < 50; k++) begin
          // Now and then let the pipeline run dry before the next pixel.
          if ($urandom_range(99) == 0) drain_pipeline();
          while ($urandom_range(99) < gap_pct[phase]) idle_cycle();
          px.bg = {rand_chan(), rand_chan(), rand_chan()};
          for (i = 0; i < PHYS_LAYERS; i++) px.level[i] = rand_chan();
          send_pixel(px);
          pending_px.push_back(blend_pixel(px));
        end
      end
    end

    drain_pipeline();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
